// ----- sv/d96_pkg.sv -----
// Package for the 96-bit scaled decimal add/subtract pipeline.
// Holds widths, special codes and the stage payload type; no dependencies.
`default_nettype none
package d96_pkg;
    localparam int MANT_W      = 96;
    localparam int SCALE_W     = 5;
    localparam int MAX_SCALE_C = 28;
    localparam int STEPS       = 28;
    // worst case: no multiply fits, one stage marks it, then three word stages per divide
    localparam int ALIGN_STAGES = 3 * STEPS + 1;

    localparam logic [1:0] SP_FINITE = 2'd0;
    localparam logic [1:0] SP_POS_OV = 2'd1;
    localparam logic [1:0] SP_NEG_OV = 2'd2;

    // word of the higher-scale mantissa that the next divide stage works on
    localparam logic [1:0] WORD_LO  = 2'd0;
    localparam logic [1:0] WORD_MID = 2'd1;
    localparam logic [1:0] WORD_HI  = 2'd2;

    // x / 10 == (x * DIV10_RECIP) >> DIV10_SHIFT for any x below 2^38
    localparam logic [35:0] DIV10_RECIP = 36'd54975581389;
    localparam int          DIV10_SHIFT = 39;

    typedef struct packed {
        logic                mode;
        logic [MANT_W-1:0]   am;
        logic [SCALE_W-1:0]  asc;
        logic                aneg;
        logic [MANT_W-1:0]   bm;
        logic [SCALE_W-1:0]  bsc;
        logic                bneg;
        logic                a_up;   // a is the higher-scale operand
        logic                stuck;
        logic [1:0]          div_word;
        logic [3:0]          rem;
        logic [1:0]          special;
    } d96_item_t;
endpackage
`default_nettype wire

// ----- sv/decimal96_add_sub_top.sv -----
// Top level of the scaled decimal add/subtract pipeline.
// Uses d96_pkg and d96_align_stage.
//
// Usage: present an operand pair on the input channel (valid/ready); the
// result comes out on the output channel (valid/ready), one per request,
// in order. Scales above 28 are treated as 28.
// Pipeline: one input register, 85 alignment stages, then the add/subtract
// register. Each alignment stage multiplies by ten, marks that no multiply
// fits, or divides one 32-bit word of the higher-scale mantissa by ten; the
// worst case is one mark and 28 divides of three words each. Throughput: one
// request per cycle while the receiver does not stall; the pipeline depth
// set by the worst-case alignment fixes latency, not rate.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls, the whole pipeline holds; in_ready is low only
// while the output register is full and not being taken.
`default_nettype none
module decimal96_add_sub_top
    import d96_pkg::*;
#(
    parameter int NSTAGE = ALIGN_STAGES
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         mode,
    input  wire logic [63:0]  a_mant_lo,
    input  wire logic [31:0]  a_mant_hi,
    input  wire logic [4:0]   a_scale,
    input  wire logic         a_neg,
    input  wire logic [1:0]   a_special,
    input  wire logic [63:0]  b_mant_lo,
    input  wire logic [31:0]  b_mant_hi,
    input  wire logic [4:0]   b_scale,
    input  wire logic         b_neg,
    input  wire logic [1:0]   b_special,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [63:0]       r_mant_lo,
    output logic [31:0]       r_mant_hi,
    output logic [4:0]        r_scale,
    output logic              r_neg,
    output logic [1:0]        r_special
);
    logic en;
    logic      v_reg [NSTAGE+1];
    d96_item_t it_reg [NSTAGE+1];
    d96_item_t ld;
    logic [4:0] asc_c, bsc_c;

    assign en = !out_valid || out_ready;
    assign in_ready = en;

    always_comb
    begin
        asc_c = (a_scale > 5'(MAX_SCALE_C)) ? 5'(MAX_SCALE_C) : a_scale;
        bsc_c = (b_scale > 5'(MAX_SCALE_C)) ? 5'(MAX_SCALE_C) : b_scale;
        ld.mode     = mode;
        ld.am       = {a_mant_hi, a_mant_lo};
        ld.asc      = asc_c;
        ld.aneg     = a_neg;
        ld.bm       = {b_mant_hi, b_mant_lo};
        ld.bsc      = bsc_c;
        ld.bneg     = b_neg;
        ld.a_up     = asc_c > bsc_c;
        ld.stuck    = 1'b0;
        ld.div_word = WORD_HI;
        ld.rem      = 4'd0;
        ld.special  = (a_special != SP_FINITE) ? a_special : b_special;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            it_reg[0] <= ld;
    end

    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_align
        d96_align_stage u_stage (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .in_valid      (v_reg[g]),
            .in_item       (it_reg[g]),
            .out_valid_reg (v_reg[g+1]),
            .out_item_reg  (it_reg[g+1])
        );
    end

    // final add or subtract on aligned operands
    d96_item_t f;
    logic [MANT_W:0] sum;
    logic [MANT_W-1:0] dif_ab, dif_ba, r_m_next;
    logic bneg_eff, a_gt, eq;
    logic [4:0] r_s_next;
    logic r_n_next;
    logic [1:0] r_sp_next;
    logic out_valid_reg;
    logic [MANT_W-1:0] r_m_reg;
    logic [4:0] r_s_reg;
    logic r_n_reg;
    logic [1:0] r_sp_reg;

    always_comb
    begin
        f = it_reg[NSTAGE];
        eq = f.am == f.bm;
        a_gt = f.am > f.bm;
        bneg_eff = f.bneg ^ f.mode;
        sum = {1'b0, f.am} + {1'b0, f.bm};
        dif_ab = f.am - f.bm;
        dif_ba = f.bm - f.am;
        r_m_next = '0;
        r_s_next = '0;
        r_n_next = 1'b0;
        r_sp_next = SP_FINITE;
        if (f.special != SP_FINITE)
            r_sp_next = f.special;
        else if (f.mode && f.aneg == f.bneg && eq)
            r_sp_next = SP_FINITE;
        else if (f.aneg == bneg_eff)
        begin
            if (sum[MANT_W])
                r_sp_next = f.aneg ? SP_NEG_OV : SP_POS_OV;
            else
            begin
                r_m_next = sum[MANT_W-1:0];
                r_s_next = f.asc;
                r_n_next = f.aneg;
            end
        end
        else if (a_gt)
        begin
            r_m_next = dif_ab;
            r_s_next = f.asc;
            r_n_next = f.aneg;
        end
        else
        begin
            r_m_next = dif_ba;
            r_s_next = f.bsc;
            r_n_next = bneg_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_reg[NSTAGE];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_m_reg  <= r_m_next;
            r_s_reg  <= r_s_next;
            r_n_reg  <= r_n_next;
            r_sp_reg <= r_sp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_mant_lo = r_m_reg[63:0];
    assign r_mant_hi = r_m_reg[95:64];
    assign r_scale   = r_s_reg;
    assign r_neg     = r_n_reg;
    assign r_special = r_sp_reg;
endmodule
`default_nettype wire

// ----- sv/d96_align_stage.sv -----
// One alignment stage: multiply the low-scale mantissa by ten if it fits, else mark
// stuck, then divide a 32-bit word of the high-scale mantissa by ten. Uses d96_pkg.
`default_nettype none
module d96_align_stage
    import d96_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire d96_item_t in_item,
    output logic           out_valid_reg,
    output d96_item_t      out_item_reg
);
    d96_item_t item_next;
    logic [MANT_W+3:0] dn_m, prod;
    logic [MANT_W-1:0] up_m, up_m_next;
    logic [SCALE_W-1:0] up_s, dn_s;
    logic [31:0] word, quo;
    logic [35:0] cur, quo_x10, rem_full;
    logic [71:0] recip;

    always_comb
    begin
        item_next = in_item;
        up_m = in_item.a_up ? in_item.am : in_item.bm;
        dn_m = {4'd0, in_item.a_up ? in_item.bm : in_item.am};
        up_s = in_item.a_up ? in_item.asc : in_item.bsc;
        dn_s = in_item.a_up ? in_item.bsc : in_item.asc;
        prod = (dn_m << 3) + (dn_m << 1);

        // long division by ten, one word per stage, top word first
        unique case (in_item.div_word)
            WORD_HI:  word = up_m[95:64];
            WORD_MID: word = up_m[63:32];
            WORD_LO:  word = up_m[31:0];
            default:  word = '0;
        endcase
        cur = {in_item.rem, word};
        recip = {36'd0, cur} * {36'd0, DIV10_RECIP};
        quo = recip[DIV10_SHIFT+31:DIV10_SHIFT];
        quo_x10 = {1'b0, quo, 3'd0} + {3'd0, quo, 1'b0};
        rem_full = cur - quo_x10;
        up_m_next = up_m;
        unique case (in_item.div_word)
            WORD_HI:  up_m_next[95:64] = quo;
            WORD_MID: up_m_next[63:32] = quo;
            WORD_LO:  up_m_next[31:0]  = quo;
            default:  up_m_next = up_m;
        endcase

        if (in_item.special == SP_FINITE && up_s > dn_s)
        begin
            if (!in_item.stuck && dn_s < SCALE_W'(MAX_SCALE_C)
                && prod[MANT_W+3:MANT_W] == 4'd0)
            begin
                if (in_item.a_up)
                begin
                    item_next.bm  = prod[MANT_W-1:0];
                    item_next.bsc = dn_s + 1'b1;
                end
                else
                begin
                    item_next.am  = prod[MANT_W-1:0];
                    item_next.asc = dn_s + 1'b1;
                end
            end
            else if (!in_item.stuck)
                item_next.stuck = 1'b1;
            else
            begin
                if (in_item.a_up)
                    item_next.am = up_m_next;
                else
                    item_next.bm = up_m_next;
                if (in_item.div_word == WORD_LO)
                begin
                    // last word done: drop one decimal place
                    item_next.div_word = WORD_HI;
                    item_next.rem      = 4'd0;
                    if (in_item.a_up)
                        item_next.asc = up_s - 1'b1;
                    else
                        item_next.bsc = up_s - 1'b1;
                end
                else
                begin
                    item_next.div_word = in_item.div_word - 1'b1;
                    item_next.rem      = rem_full[3:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item_reg <= item_next;
    end
endmodule
`default_nettype wire
